// ----- sv/mssr_pkg.sv -----
// ----------------------------------------------------------------------------
// mssr_pkg: shared types and constants of the mailbox service sequencer
// item formats, operation and status codes, service ids and register indexes
// ----------------------------------------------------------------------------
package mssr_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_BUSY,
    PH_STALE,
    PH_READY,
    PH_ACK,
    PH_REPLY,
    PH_BLOCK
  } phase_t;

  localparam logic ACT_CMD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [1:0] CMD_PING  = 2'd0;
  localparam logic [1:0] CMD_BOOT  = 2'd1;
  localparam logic [1:0] CMD_VTOR  = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  localparam logic [3:0] OP_RD_TX     = 4'd0;
  localparam logic [3:0] OP_RD_RX     = 4'd1;
  localparam logic [3:0] OP_RD_READY  = 4'd2;
  localparam logic [3:0] OP_WR_ACCESS = 4'd3;
  localparam logic [3:0] OP_WR_SET    = 4'd4;
  localparam logic [3:0] OP_WR_CLEAR  = 4'd5;
  localparam logic [3:0] OP_WR_BLOCK  = 4'd6;
  localparam logic [3:0] OP_RD_BLOCK  = 4'd7;
  localparam logic [3:0] OP_DONE      = 4'd8;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_TIMEOUT = 3'd2;
  localparam logic [2:0] ST_NOCONN  = 3'd3;
  localparam logic [2:0] ST_SEERR   = 3'd4;

  localparam logic [9:0] SVC_HEARTBEAT = 10'd0;
  localparam logic [9:0] SVC_BOOT      = 10'd501;
  localparam logic [9:0] SVC_VTOR      = 10'd505;

  localparam logic [30:0] ERR_CLAMP = 31'h7FFF_FFFF;

  localparam logic [2:0] REG_READY_LIMIT = 3'd0;
  localparam logic [2:0] REG_ACK_LIMIT   = 3'd1;
  localparam logic [2:0] REG_REPLY_LIMIT = 3'd2;
  localparam logic [2:0] REG_ATTEMPTS    = 3'd3;
  localparam logic [2:0] REG_POINTER     = 3'd4;

  localparam logic [19:0] READY_LIMIT_RESET = 20'd100000;
  localparam logic [19:0] ACK_LIMIT_RESET   = 20'd100000;
  localparam logic [19:0] REPLY_LIMIT_RESET = 20'd1000000;
  localparam logic [6:0]  ATTEMPTS_RESET    = 7'd100;

  localparam int QDEPTH = 8;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int MAXRES = 3;

  typedef struct packed {
    logic        action;
    logic [1:0]  command_kind;
    logic [31:0] target_cpu;
    logic [31:0] target_address;
    logic [31:0] read_value;
    logic [15:0] reply_header_error;
    logic [31:0] reply_service_error;
  } cmd_item_t;

  typedef struct packed {
    logic [3:0]  operation;
    logic [31:0] write_value;
    logic [9:0]  request_service;
    logic [31:0] request_cpu;
    logic [31:0] request_address;
    logic [2:0]  status;
    logic [30:0] error_value;
    logic        last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0]            count;
    result_t [MAXRES-1:0]  entry;
  } batch_t;

  typedef struct packed {
    logic [19:0] ready_poll_limit;
    logic [19:0] ack_poll_limit;
    logic [19:0] reply_poll_limit;
    logic [6:0]  heartbeat_attempts;
    logic [31:0] request_pointer;
  } cfg_t;

  function automatic result_t mk_op(logic [3:0] op, logic [31:0] wv);
    result_t r;
    r = '0;
    r.operation   = op;
    r.write_value = wv;
    return r;
  endfunction

  function automatic result_t mk_block(logic [9:0] svc, logic [31:0] cpu,
                                       logic [31:0] addr);
    result_t r;
    r = '0;
    r.operation       = OP_WR_BLOCK;
    r.request_service = svc;
    r.request_cpu     = cpu;
    r.request_address = addr;
    return r;
  endfunction

  function automatic result_t mk_done(logic [2:0] st, logic [30:0] err);
    result_t r;
    r = '0;
    r.operation   = OP_DONE;
    r.status      = st;
    r.error_value = err;
    return r;
  endfunction

endpackage

// ----- sv/mssr_engine.sv -----
// ----------------------------------------------------------------------------
// mssr_engine: request sequencer state machine
// takes one item per cycle while accept is high and produces up to three results for it
// ----------------------------------------------------------------------------
module mssr_engine import mssr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  cmd_item_t item,
  input  cfg_t      cfg,
  output batch_t    batch
);

  phase_t      phase, phase_next;
  logic [19:0] poll_count, poll_count_next;
  logic [6:0]  attempt_count, attempt_count_next;
  logic [1:0]  pending_command, pending_command_next;
  logic        in_boot_stage, in_boot_stage_next;
  logic        in_heartbeat, in_heartbeat_next;
  logic [31:0] held_cpu, held_cpu_next;
  logic [31:0] held_address, held_address_next;

  logic        rv_nz;
  logic        wait_ok;
  logic [19:0] poll_inc;
  logic [19:0] limit_sel;
  logic        exhausted;
  logic [7:0]  att_inc;
  logic        give_up;
  logic        err_any;
  logic [31:0] err_raw;
  logic [30:0] err_val;
  logic        vtor_stage;
  logic [9:0]  svc_sel;

  assign rv_nz     = item.read_value != 32'd0;
  assign poll_inc  = poll_count + 20'd1;
  assign exhausted = poll_inc >= limit_sel;
  assign att_inc   = {1'b0, attempt_count} + 8'd1;
  assign give_up   = att_inc >= {1'b0, cfg.heartbeat_attempts};
  assign err_any   = (item.reply_header_error != 16'd0) || (item.reply_service_error != 32'd0);
  assign err_raw   = (item.reply_service_error != 32'd0) ? item.reply_service_error
                                                         : {16'd0, item.reply_header_error};
  assign err_val   = err_raw[31] ? ERR_CLAMP : err_raw[30:0];
  assign vtor_stage = (pending_command == CMD_VTOR) ||
                      ((pending_command == CMD_START) && !in_boot_stage);
  assign svc_sel   = vtor_stage ? SVC_VTOR : SVC_BOOT;

  always_comb begin
    case (phase)
      PH_READY: begin
        limit_sel = cfg.ready_poll_limit;
        wait_ok   = rv_nz;
      end
      PH_ACK: begin
        limit_sel = cfg.ack_poll_limit;
        wait_ok   = !rv_nz;
      end
      default: begin
        limit_sel = cfg.reply_poll_limit;
        wait_ok   = rv_nz;
      end
    endcase
  end

  // next state
  always_comb begin
    phase_next           = phase;
    poll_count_next      = poll_count;
    attempt_count_next   = attempt_count;
    pending_command_next = pending_command;
    in_boot_stage_next   = in_boot_stage;
    in_heartbeat_next    = in_heartbeat;
    held_cpu_next        = held_cpu;
    held_address_next    = held_address;
    if (accept) begin
      if (item.action == ACT_CMD) begin
        if (phase == PH_IDLE) begin
          pending_command_next = item.command_kind;
          held_cpu_next        = item.target_cpu;
          held_address_next    = item.target_address;
          in_boot_stage_next   = 1'b0;
          in_heartbeat_next    = 1'b0;
          phase_next           = PH_BUSY;
        end
      end else begin
        case (phase)
          PH_BUSY: begin
            if (rv_nz) begin
              phase_next = PH_IDLE;
            end else begin
              attempt_count_next = 7'd0;
              in_heartbeat_next  = 1'b1;
              phase_next         = PH_STALE;
            end
          end
          PH_STALE: begin
            poll_count_next = 20'd0;
            phase_next      = PH_READY;
          end
          PH_READY, PH_ACK, PH_REPLY: begin
            if (wait_ok) begin
              poll_count_next = 20'd0;
              case (phase)
                PH_READY: phase_next = PH_ACK;
                PH_ACK:   phase_next = PH_REPLY;
                default:  phase_next = PH_BLOCK;
              endcase
            end else begin
              poll_count_next = poll_inc;
              if (exhausted) begin
                if (!in_heartbeat || give_up) begin
                  phase_next = PH_IDLE;
                end else begin
                  attempt_count_next = att_inc[6:0];
                  phase_next         = PH_STALE;
                end
              end
            end
          end
          PH_BLOCK: begin
            if (in_heartbeat) begin
              if (pending_command == CMD_PING) begin
                phase_next = PH_IDLE;
              end else begin
                in_heartbeat_next = 1'b0;
                phase_next        = PH_STALE;
              end
            end else if (err_any) begin
              phase_next = PH_IDLE;
            end else if ((pending_command == CMD_START) && !in_boot_stage) begin
              in_boot_stage_next = 1'b1;
              in_heartbeat_next  = 1'b0;
              phase_next         = PH_BUSY;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end
  end

  // results
  always_comb begin
    logic [1:0] k;
    k     = 2'd0;
    batch = '0;
    if (accept) begin
      if (item.action == ACT_CMD) begin
        if (phase == PH_IDLE) begin
          batch.entry[k] = mk_op(OP_RD_TX, 32'd0);
          k = k + 2'd1;
        end
      end else begin
        case (phase)
          PH_BUSY: begin
            if (rv_nz) begin
              batch.entry[k] = mk_done(ST_BUSY, 31'd0);
              k = k + 2'd1;
            end else begin
              batch.entry[k] = mk_block(SVC_HEARTBEAT, 32'd0, 32'd0);
              k = k + 2'd1;
              batch.entry[k] = mk_op(OP_RD_RX, 32'd0);
              k = k + 2'd1;
            end
          end
          PH_STALE: begin
            if (rv_nz) begin
              batch.entry[k] = mk_op(OP_WR_CLEAR, item.read_value);
              k = k + 2'd1;
            end
            batch.entry[k] = mk_op(OP_WR_ACCESS, 32'd1);
            k = k + 2'd1;
            batch.entry[k] = mk_op(OP_RD_READY, 32'd0);
            k = k + 2'd1;
          end
          PH_READY, PH_ACK, PH_REPLY: begin
            if (wait_ok) begin
              case (phase)
                PH_READY: begin
                  batch.entry[k] = mk_op(OP_WR_SET, cfg.request_pointer);
                  k = k + 2'd1;
                  batch.entry[k] = mk_op(OP_RD_TX, 32'd0);
                  k = k + 2'd1;
                end
                PH_ACK: begin
                  batch.entry[k] = mk_op(OP_RD_RX, 32'd0);
                  k = k + 2'd1;
                end
                default: begin
                  batch.entry[k] = mk_op(OP_WR_CLEAR, item.read_value);
                  k = k + 2'd1;
                  batch.entry[k] = mk_op(OP_WR_ACCESS, 32'd0);
                  k = k + 2'd1;
                  batch.entry[k] = mk_op(OP_RD_BLOCK, 32'd0);
                  k = k + 2'd1;
                end
              endcase
            end else if (exhausted) begin
              batch.entry[k] = mk_op(OP_WR_ACCESS, 32'd0);
              k = k + 2'd1;
              if (!in_heartbeat) begin
                batch.entry[k] = mk_done(ST_TIMEOUT, 31'd0);
                k = k + 2'd1;
              end else if (give_up) begin
                batch.entry[k] = mk_done(ST_NOCONN, 31'd0);
                k = k + 2'd1;
              end else begin
                batch.entry[k] = mk_block(SVC_HEARTBEAT, 32'd0, 32'd0);
                k = k + 2'd1;
                batch.entry[k] = mk_op(OP_RD_RX, 32'd0);
                k = k + 2'd1;
              end
            end else begin
              case (phase)
                PH_READY: batch.entry[k] = mk_op(OP_RD_READY, 32'd0);
                PH_ACK:   batch.entry[k] = mk_op(OP_RD_TX, 32'd0);
                default:  batch.entry[k] = mk_op(OP_RD_RX, 32'd0);
              endcase
              k = k + 2'd1;
            end
          end
          PH_BLOCK: begin
            if (in_heartbeat) begin
              if (pending_command == CMD_PING) begin
                batch.entry[k] = mk_done(ST_OK, 31'd0);
                k = k + 2'd1;
              end else begin
                batch.entry[k] = mk_block(svc_sel, held_cpu, held_address);
                k = k + 2'd1;
                batch.entry[k] = mk_op(OP_RD_RX, 32'd0);
                k = k + 2'd1;
              end
            end else if (err_any) begin
              batch.entry[k] = mk_done(ST_SEERR, err_val);
              k = k + 2'd1;
            end else if ((pending_command == CMD_START) && !in_boot_stage) begin
              batch.entry[k] = mk_op(OP_RD_TX, 32'd0);
              k = k + 2'd1;
            end else begin
              batch.entry[k] = mk_done(ST_OK, 31'd0);
              k = k + 2'd1;
            end
          end
          default: begin
            k = 2'd0;
          end
        endcase
      end
    end
    if (k != 2'd0) begin
      batch.entry[k - 2'd1].last_of_run = 1'b1;
    end
    batch.count = k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      poll_count      <= 20'd0;
      attempt_count   <= 7'd0;
      pending_command <= 2'd0;
      in_boot_stage   <= 1'b0;
      in_heartbeat    <= 1'b0;
      held_cpu        <= 32'd0;
      held_address    <= 32'd0;
    end else begin
      phase           <= phase_next;
      poll_count      <= poll_count_next;
      attempt_count   <= attempt_count_next;
      pending_command <= pending_command_next;
      in_boot_stage   <= in_boot_stage_next;
      in_heartbeat    <= in_heartbeat_next;
      held_cpu        <= held_cpu_next;
      held_address    <= held_address_next;
    end
  end

  a_cmd_starts: assert property (@(posedge clk) disable iff (rst)
    accept && (item.action == ACT_CMD) && (phase == PH_IDLE) |=> phase == PH_BUSY)
    else $error("accepted command in idle did not start a request");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) && !(accept && (item.action == ACT_CMD)) |=> phase == PH_IDLE)
    else $error("left idle without a command");

  a_silent_no_change: assert property (@(posedge clk) disable iff (rst)
    accept && (batch.count == 2'd0) |=> $stable(phase))
    else $error("item without results changed the phase");

endmodule

// ----- sv/mssr_out_queue.sv -----
// ----------------------------------------------------------------------------
// mssr_out_queue: result queue
// takes up to three results per cycle and hands them out one at a time
// ----------------------------------------------------------------------------
module mssr_out_queue import mssr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  batch_t  batch,
  output logic    room,
  output logic    rsp_valid,
  input  logic    rsp_stall,
  output result_t rsp_item
);

  result_t        slot [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count, count_next;
  logic           pop;

  assign room      = count <= (QAW+1)'(QDEPTH - MAXRES);
  assign rsp_valid = count != '0;
  assign rsp_item  = slot[rd_ptr];
  assign pop       = rsp_valid && !rsp_stall;
  assign count_next = count + (QAW+1)'(batch.count) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAXRES; i++) begin
      if (batch.count > 2'(i)) begin
        slot[wr_ptr + QAW'(i)] <= batch.entry[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QAW'(batch.count);
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (batch.count != 2'd0) |-> count <= (QAW+1)'(QDEPTH - MAXRES))
    else $error("results pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count beyond depth");

  a_empty_pointers: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (rd_ptr == wr_ptr))
    else $error("empty queue with unequal pointers");

endmodule

// ----- sv/mailbox_service_request_sequencer.sv -----
// ----------------------------------------------------------------------------
// mailbox_service_request_sequencer: mailbox service request sequencer
// runs ping, boot, set-vtor and start requests to a secure enclave
// ----------------------------------------------------------------------------
// the req channel carries commands and the result of each bus read; the rsp
// channel carries bus operations and a final done item with status. an item
// is taken when valid is high and stall is low. each req item yields zero to
// three rsp items, the last one flagged by last_of_run.
// one req item per cycle is taken while req stall is low; rsp items leave
// at one per cycle while rsp stall is low, from an eight-entry queue, and
// req stall rises while fewer than three entries are free, so a stalled
// receiver backs up into req within a few items. the cfg channel is always
// ready and its writes are registered; indexes 0 to 4 select ready, ack and
// reply poll limits, heartbeat attempts and the request pointer, other
// indexes are dropped. write cfg only while idle.
// reset (synchronous, active high) clears the queue, returns the sequencer
// to idle and loads the default limits.
// ----------------------------------------------------------------------------
module mailbox_service_request_sequencer import mssr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  cmd_item_t   req_item,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output result_t     rsp_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t   cfg;
  batch_t batch;
  logic   room;
  logic   accept;

  assign cfg_ready = 1'b1;
  assign req_stall = !room;
  assign accept    = req_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ready_poll_limit   <= READY_LIMIT_RESET;
      cfg.ack_poll_limit     <= ACK_LIMIT_RESET;
      cfg.reply_poll_limit   <= REPLY_LIMIT_RESET;
      cfg.heartbeat_attempts <= ATTEMPTS_RESET;
      cfg.request_pointer    <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_READY_LIMIT: cfg.ready_poll_limit   <= cfg_data[19:0];
        REG_ACK_LIMIT:   cfg.ack_poll_limit     <= cfg_data[19:0];
        REG_REPLY_LIMIT: cfg.reply_poll_limit   <= cfg_data[19:0];
        REG_ATTEMPTS:    cfg.heartbeat_attempts <= cfg_data[6:0];
        REG_POINTER:     cfg.request_pointer    <= cfg_data;
        default:         cfg.request_pointer    <= cfg.request_pointer;
      endcase
    end
  end

  mssr_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (req_item),
    .cfg    (cfg),
    .batch  (batch)
  );

  mssr_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .batch     (batch),
    .room      (room),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

endmodule
